// ----- rtl/sor_pkg.sv -----
package sor_pkg;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_TICK    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_RECT    = 2'd0,
    MODE_ELLIPSE = 2'd1,
    MODE_TRI     = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_SHAPE_MODE    = 2'd0,
    REG_DRAW_COLOR    = 2'd1,
    REG_CANVAS_WIDTH  = 2'd2,
    REG_CANVAS_HEIGHT = 2'd3
  } reg_index_t;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_RECT_H = 7'b0000010,
    PH_RECT_V = 7'b0000100,
    PH_ELL_1  = 7'b0001000,
    PH_ELL_2  = 7'b0010000,
    PH_TRI_E  = 7'b0100000,
    PH_TRI_B  = 7'b1000000
  } phase_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_UPD    = 6'b000100,
    ST_DEC    = 6'b001000,
    ST_SETTLE = 6'b010000,
    ST_EMIT   = 6'b100000
  } seq_t;

  localparam logic [1:0] MODE_RESET   = 2'd0;
  localparam logic [8:0] CANVAS_RESET = 9'd32;

  localparam logic [2:0] MS_AA      = 3'd0;
  localparam logic [2:0] MS_BB      = 3'd1;
  localparam logic [2:0] MS_AAB     = 3'd2;
  localparam logic [2:0] MS_TX2     = 3'd3;
  localparam logic [2:0] MS_BB_TX2  = 3'd4;
  localparam logic [2:0] MS_TY2     = 3'd5;
  localparam logic [2:0] MS_AA_TY2  = 3'd6;
  localparam logic [2:0] MS_AA_BB   = 3'd7;

endpackage

// ----- rtl/shape_outline_rasterizer_top.sv -----
// Outline draw engine: rectangle, midpoint ellipse or 45-degree triangle.
// Input channel (in_valid/in_ready): kind, pos_x, pos_y. A press request
// records the start corner and arms the block; a release request, while
// armed and no shape is in progress, sets up the shape (ellipse setup runs
// three passes of the shared multiplier). Press and release
// give no result. A tick request runs one loop step and gives one to four
// result requests on the output channel (out_valid/out_ready).
// A tick goes through update (and decision for the ellipse) and settle, then
// emits its valid points in order up to its last pixel, or one empty result with
// nothing to draw; each loop change repeats settle, and the ellipse step that
// crosses into its second region adds five multiplier passes. All products come
// from one 24x24 multiplier under the sequencer; in_ready is high only while it
// is idle. The output register holds a result while the receiver stalls; the
// sequencer waits in emit until the register frees up. Reset (rst, synchronous)
// clears config to defaults, disarms and idles. Config (cfg_we, cfg_index,
// cfg_data) must be written only while idle; the block does not enforce it.
module shape_outline_rasterizer_top #(
  parameter int MAX_DIM = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_enable,
  output logic [7:0]  pix_x,
  output logic [7:0]  pix_y,
  output logic        step_last,
  output logic        shape_done
);

  logic [1:0]  shape_mode;
  logic [8:0]  canvas_width;
  logic [8:0]  canvas_height;

  logic [7:0]  corner_a_x;
  logic [7:0]  corner_a_y;
  logic        armed;
  sor_pkg::phase_t phase;
  sor_pkg::seq_t   seq;
  logic [7:0]  box_bounds [4];
  logic signed [9:0]  walk_x;
  logic signed [9:0]  walk_y;
  logic signed [25:0] step_dx;
  logic signed [25:0] step_dy;
  logic signed [39:0] decision;
  logic [15:0] axis_aa;
  logic [15:0] axis_bb;
  logic signed [23:0] tmp;
  logic [2:0]  mstep;
  logic        use_dx;
  logic        use_dy;
  logic        from_tick;
  logic        busy;
  logic [7:0]  buf_x [4];
  logic [7:0]  buf_y [4];
  logic [3:0]  buf_ok;
  logic [1:0]  ptr;

  logic accept_in;
  assign in_ready  = (seq == sor_pkg::ST_IDLE);
  assign accept_in = in_valid && in_ready;

  // shared multiplier
  logic signed [23:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [47:0] prod;
  logic signed [39:0] p40;

  always_comb begin
    unique case (mstep)
      sor_pkg::MS_AA: begin
        mul_a = signed'({16'd0, box_bounds[2]});
        mul_b = signed'({16'd0, box_bounds[2]});
      end
      sor_pkg::MS_BB: begin
        mul_a = signed'({16'd0, box_bounds[3]});
        mul_b = signed'({16'd0, box_bounds[3]});
      end
      sor_pkg::MS_AAB: begin
        mul_a = signed'({8'd0, axis_aa});
        mul_b = signed'({16'd0, box_bounds[3]});
      end
      sor_pkg::MS_TX2: begin
        mul_a = signed'({{13{walk_x[9]}}, walk_x, 1'b1});
        mul_b = signed'({{13{walk_x[9]}}, walk_x, 1'b1});
      end
      sor_pkg::MS_BB_TX2: begin
        mul_a = signed'({8'd0, axis_bb});
        mul_b = tmp;
      end
      sor_pkg::MS_TY2: begin
        mul_a = signed'({{14{walk_y[9]}}, walk_y}) - 24'sd1;
        mul_b = signed'({{14{walk_y[9]}}, walk_y}) - 24'sd1;
      end
      sor_pkg::MS_AA_TY2: begin
        mul_a = signed'({8'd0, axis_aa});
        mul_b = tmp;
      end
      default: begin
        mul_a = signed'({8'd0, axis_aa});
        mul_b = signed'({8'd0, axis_bb});
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign p40  = prod[39:0];

  // geometry
  logic signed [11:0] wx12, wy12, b0, b1, b2, b3, mid12, h12;
  logic [8:0] mid_sum;
  logic [7:0] h8;
  assign wx12    = {{2{walk_x[9]}}, walk_x};
  assign wy12    = {{2{walk_y[9]}}, walk_y};
  assign b0      = signed'({4'd0, box_bounds[0]});
  assign b1      = signed'({4'd0, box_bounds[1]});
  assign b2      = signed'({4'd0, box_bounds[2]});
  assign b3      = signed'({4'd0, box_bounds[3]});
  assign mid_sum = {1'b0, box_bounds[0]} + {1'b0, box_bounds[2]};
  assign mid12   = signed'({4'd0, mid_sum[8:1]});
  assign h8      = box_bounds[3] - box_bounds[1];
  assign h12     = signed'({4'd0, h8});

  logic signed [11:0] pt_x [4];
  logic signed [11:0] pt_y [4];
  logic [3:0] pt_en;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pt_x[i] = '0;
      pt_y[i] = '0;
    end
    pt_en = 4'b0000;
    unique case (phase)
      sor_pkg::PH_RECT_H: begin
        pt_x[0] = wx12; pt_y[0] = b1;
        pt_x[1] = wx12; pt_y[1] = b3;
        pt_en = 4'b0011;
      end
      sor_pkg::PH_RECT_V: begin
        pt_x[0] = b0; pt_y[0] = wy12;
        pt_x[1] = b2; pt_y[1] = wy12;
        pt_en = 4'b0011;
      end
      sor_pkg::PH_ELL_1, sor_pkg::PH_ELL_2: begin
        pt_x[0] = b0 + wx12; pt_y[0] = b1 + wy12;
        pt_x[1] = b0 - wx12; pt_y[1] = b1 + wy12;
        pt_x[2] = b0 + wx12; pt_y[2] = b1 - wy12;
        pt_x[3] = b0 - wx12; pt_y[3] = b1 - wy12;
        pt_en = 4'b1111;
      end
      sor_pkg::PH_TRI_E: begin
        pt_x[0] = mid12 - wy12; pt_y[0] = b1 + wy12;
        pt_x[1] = mid12 + wy12; pt_y[1] = b1 + wy12;
        pt_en = 4'b0011;
      end
      sor_pkg::PH_TRI_B: begin
        pt_x[0] = wx12; pt_y[0] = b3;
        pt_en = 4'b0001;
      end
      default: begin
        pt_en = 4'b0000;
      end
    endcase
  end

  logic [15:0] lim_w, lim_h;
  logic [3:0]  pt_ok;
  assign lim_w = ({7'd0, canvas_width} > 16'(MAX_DIM)) ? 16'(MAX_DIM)
                                                       : {7'd0, canvas_width};
  assign lim_h = ({7'd0, canvas_height} > 16'(MAX_DIM)) ? 16'(MAX_DIM)
                                                        : {7'd0, canvas_height};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pt_ok[i] = pt_en[i] && !pt_x[i][11] && !pt_y[i][11]
                 && ({4'd0, pt_x[i]} < lim_w) && ({4'd0, pt_y[i]} < lim_h);
    end
  end

  // release setup
  logic [7:0] rs_sx, rs_ex, rs_sy, rs_ey, rs_dx, rs_dy;
  assign rs_sx = (corner_a_x < pos_x) ? corner_a_x : pos_x;
  assign rs_ex = (corner_a_x < pos_x) ? pos_x : corner_a_x;
  assign rs_sy = (corner_a_y < pos_y) ? corner_a_y : pos_y;
  assign rs_ey = (corner_a_y < pos_y) ? pos_y : corner_a_y;
  assign rs_dx = rs_ex - rs_sx;
  assign rs_dy = rs_ey - rs_sy;

  // decision step term
  logic signed [39:0] term40;
  logic signed [39:0] base40;
  assign base40 = (phase == sor_pkg::PH_ELL_1) ? signed'({24'd0, axis_bb})
                                               : signed'({24'd0, axis_aa});
  assign term40 = (use_dx ? {{14{step_dx[25]}}, step_dx} : 40'sd0)
                - (use_dy ? {{14{step_dy[25]}}, step_dy} : 40'sd0)
                + base40;

  logic [25:0] two_aa, two_bb;
  assign two_aa = {9'd0, axis_aa, 1'b0};
  assign two_bb = {9'd0, axis_bb, 1'b0};

  logic [3:0] rest_ok;
  logic       emit_last;
  logic       slot_free;
  logic       emit_now;
  assign rest_ok   = (buf_ok >> ptr) >> 1;
  assign emit_last = (rest_ok == 4'd0);
  assign slot_free = !out_valid || out_ready;
  assign emit_now  = (seq == sor_pkg::ST_EMIT) && slot_free
                     && ((buf_ok == 4'd0) || buf_ok[ptr]);

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode    <= sor_pkg::MODE_RESET;
      canvas_width  <= sor_pkg::CANVAS_RESET;
      canvas_height <= sor_pkg::CANVAS_RESET;
      corner_a_x    <= '0;
      corner_a_y    <= '0;
      armed         <= 1'b0;
      phase         <= sor_pkg::PH_IDLE;
      seq           <= sor_pkg::ST_IDLE;
      mstep         <= sor_pkg::MS_AA;
      from_tick     <= 1'b0;
      busy          <= 1'b0;
      ptr           <= '0;
      buf_ok        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (sor_pkg::reg_index_t'(cfg_index))
          sor_pkg::REG_SHAPE_MODE:    shape_mode    <= cfg_data[1:0];
          sor_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[8:0];
          sor_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data[8:0];
          default: ;
        endcase
      end

      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (seq)
        sor_pkg::ST_IDLE: begin
          if (accept_in) begin
            unique case (sor_pkg::kind_t'(kind))
              sor_pkg::KIND_PRESS: begin
                corner_a_x <= pos_x;
                corner_a_y <= pos_y;
                armed      <= 1'b1;
              end
              sor_pkg::KIND_RELEASE: begin
                if (armed && phase == sor_pkg::PH_IDLE) begin
                  armed     <= 1'b0;
                  from_tick <= 1'b0;
                  if (sor_pkg::mode_t'(shape_mode) != sor_pkg::MODE_ELLIPSE) begin
                    box_bounds[0] <= rs_sx;
                    box_bounds[1] <= rs_sy;
                    box_bounds[2] <= rs_ex;
                    box_bounds[3] <= rs_ey;
                  end
                  unique case (sor_pkg::mode_t'(shape_mode))
                    sor_pkg::MODE_RECT: begin
                      phase  <= sor_pkg::PH_RECT_H;
                      walk_x <= signed'({2'd0, rs_sx});
                      seq    <= sor_pkg::ST_SETTLE;
                    end
                    sor_pkg::MODE_ELLIPSE: begin
                      box_bounds[0] <= rs_sx + {1'b0, rs_dx[7:1]};
                      box_bounds[1] <= rs_sy + {1'b0, rs_dy[7:1]};
                      box_bounds[2] <= {1'b0, rs_dx[7:1]};
                      box_bounds[3] <= {1'b0, rs_dy[7:1]};
                      walk_x  <= '0;
                      walk_y  <= signed'({3'd0, rs_dy[7:1]});
                      step_dx <= '0;
                      phase   <= sor_pkg::PH_ELL_1;
                      mstep   <= sor_pkg::MS_AA;
                      seq     <= sor_pkg::ST_MUL;
                    end
                    sor_pkg::MODE_TRI: begin
                      phase  <= sor_pkg::PH_TRI_E;
                      walk_y <= '0;
                      seq    <= sor_pkg::ST_SETTLE;
                    end
                    default: begin
                      phase <= sor_pkg::PH_IDLE;
                    end
                  endcase
                end
              end
              sor_pkg::KIND_TICK: begin
                for (int i = 0; i < 4; i++) begin
                  buf_x[i] <= pt_x[i][7:0];
                  buf_y[i] <= pt_y[i][7:0];
                end
                buf_ok    <= pt_ok;
                ptr       <= '0;
                from_tick <= 1'b1;
                busy      <= (phase != sor_pkg::PH_IDLE);
                seq       <= (phase != sor_pkg::PH_IDLE) ? sor_pkg::ST_UPD
                                                         : sor_pkg::ST_EMIT;
              end
              default: ;
            endcase
          end
        end

        sor_pkg::ST_MUL: begin
          mstep <= mstep + 3'd1;
          unique case (mstep)
            sor_pkg::MS_AA:  axis_aa <= p40[15:0];
            sor_pkg::MS_BB:  axis_bb <= p40[15:0];
            sor_pkg::MS_AAB: begin
              step_dy  <= {p40[24:0], 1'b0};
              decision <= signed'({22'd0, axis_bb, 2'b00})
                        - {p40[37:0], 2'b00}
                        + signed'({24'd0, axis_aa});
              seq <= sor_pkg::ST_SETTLE;
            end
            sor_pkg::MS_TX2:    tmp <= p40[23:0];
            sor_pkg::MS_BB_TX2: decision <= p40;
            sor_pkg::MS_TY2:    tmp <= p40[23:0];
            sor_pkg::MS_AA_TY2: decision <= decision + {p40[37:0], 2'b00};
            default: begin
              decision <= decision - {p40[37:0], 2'b00};
              phase    <= sor_pkg::PH_ELL_2;
              seq      <= sor_pkg::ST_SETTLE;
            end
          endcase
        end

        sor_pkg::ST_UPD: begin
          unique case (phase)
            sor_pkg::PH_RECT_H, sor_pkg::PH_TRI_B: begin
              walk_x <= walk_x + 10'sd1;
              seq    <= sor_pkg::ST_SETTLE;
            end
            sor_pkg::PH_RECT_V, sor_pkg::PH_TRI_E: begin
              walk_y <= walk_y + 10'sd1;
              seq    <= sor_pkg::ST_SETTLE;
            end
            sor_pkg::PH_ELL_1: begin
              walk_x  <= walk_x + 10'sd1;
              step_dx <= step_dx + two_bb;
              use_dx  <= 1'b1;
              use_dy  <= !decision[39];
              if (!decision[39]) begin
                walk_y  <= walk_y - 10'sd1;
                step_dy <= step_dy - two_aa;
              end
              seq <= sor_pkg::ST_DEC;
            end
            sor_pkg::PH_ELL_2: begin
              walk_y  <= walk_y - 10'sd1;
              step_dy <= step_dy - two_aa;
              use_dy  <= 1'b1;
              use_dx  <= !(decision > 40'sd0);
              if (!(decision > 40'sd0)) begin
                walk_x  <= walk_x + 10'sd1;
                step_dx <= step_dx + two_bb;
              end
              seq <= sor_pkg::ST_DEC;
            end
            default: seq <= sor_pkg::ST_SETTLE;
          endcase
        end

        sor_pkg::ST_DEC: begin
          decision <= decision + {term40[37:0], 2'b00};
          seq      <= sor_pkg::ST_SETTLE;
        end

        sor_pkg::ST_SETTLE: begin
          if (phase == sor_pkg::PH_RECT_H && wx12 > b2) begin
            phase  <= sor_pkg::PH_RECT_V;
            walk_y <= signed'({2'd0, box_bounds[1]});
          end else if (phase == sor_pkg::PH_RECT_V && wy12 > b3) begin
            phase <= sor_pkg::PH_IDLE;
          end else if (phase == sor_pkg::PH_ELL_1 && !(step_dx < step_dy)) begin
            mstep <= sor_pkg::MS_TX2;
            seq   <= sor_pkg::ST_MUL;
          end else if (phase == sor_pkg::PH_ELL_2 && walk_y[9]) begin
            phase <= sor_pkg::PH_IDLE;
          end else if (phase == sor_pkg::PH_TRI_E && wy12 > h12) begin
            phase  <= sor_pkg::PH_TRI_B;
            walk_x <= 10'(mid12 - h12);
          end else if (phase == sor_pkg::PH_TRI_B && wx12 > mid12 + h12) begin
            phase <= sor_pkg::PH_IDLE;
          end else begin
            seq <= from_tick ? sor_pkg::ST_EMIT : sor_pkg::ST_IDLE;
          end
        end

        default: begin
          if (slot_free) begin
            if (buf_ok == 4'd0) begin
              write_enable <= 1'b0;
              pix_x        <= '0;
              pix_y        <= '0;
              step_last    <= 1'b1;
              shape_done   <= busy && (phase == sor_pkg::PH_IDLE);
              seq          <= sor_pkg::ST_IDLE;
            end else if (buf_ok[ptr]) begin
              write_enable <= 1'b1;
              pix_x        <= buf_x[ptr];
              pix_y        <= buf_y[ptr];
              step_last    <= emit_last;
              shape_done   <= emit_last && (phase == sor_pkg::PH_IDLE);
              ptr          <= ptr + 2'd1;
              if (emit_last) begin
                seq <= sor_pkg::ST_IDLE;
              end
            end else begin
              ptr <= ptr + 2'd1;
            end
          end
        end
      endcase
    end
  end

endmodule
